[rtl/gse_pkg.sv]
// Shared types, constants and helper functions of the 3x3 grayscale erosion block.
// This package has no dependencies. The kernel, output buffer and top level import it.
package gse_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int NSLOT     = 4;
    localparam int SLOT_W    = 2;
    localparam int TDATA_W   = 32;
    localparam int TPAD_W    = TDATA_W - PIX_W - 2 * COORD_W;
    localparam int DIM_MIN   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // One column of the window: top is two rows up, bot is the newest pixel.
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    typedef struct packed {
        pix_t               value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               done;
    } res_t;

    // Up to four results caused by one pixel, in raster order from slot 0 up.
    typedef struct packed {
        logic [NSLOT-1:0] mask;
        res_t [NSLOT-1:0] slot;
    } grp_t;

    function automatic pix_t min8(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t col_min(input col_t c, input logic use_top);
        pix_t v;
        v = min8(c.mid, c.bot);
        if (use_top) begin
            v = min8(v, c.top);
        end
        return v;
    endfunction

endpackage

[rtl/gse_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// The read data register only updates on a read enable. No package dependencies.
module gse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/gse_kernel.sv]
// Window arithmetic: forms the clipped 3x3 minima completed by one pixel.
// Depends on gse_pkg for the column, result and group types.
module gse_kernel #(
    parameter int COL_W = 10,
    parameter int ROW_W = 10
) (
    input  gse_pkg::col_t     cur,
    input  gse_pkg::col_t     prev1,
    input  gse_pkg::col_t     prev2,
    input  logic [COL_W-1:0]  col,
    input  logic [ROW_W-1:0]  row,
    input  logic [COL_W-1:0]  w_last,
    input  logic [ROW_W-1:0]  h_last,
    output gse_pkg::grp_t     grp
);
    import gse_pkg::*;

    logic             use_top;
    pix_t             a_pair, a_left, b_pair, b_left;
    logic             row_a, row_b, has_left, has_right;
    logic [ROW_W-1:0] row_up;
    logic [COL_W-1:0] col_left;

    assign use_top   = row > ROW_W'(1);
    assign row_up    = row - ROW_W'(1);
    assign col_left  = col - COL_W'(1);
    assign row_a     = row != '0;
    assign row_b     = row_a && (row == h_last);
    assign has_left  = col != '0;
    assign has_right = col == w_last;

    always_comb begin
        a_pair = min8(col_min(prev1, use_top), col_min(cur, use_top));
        a_left = (col > COL_W'(1)) ? min8(a_pair, col_min(prev2, use_top)) : a_pair;
        b_pair = min8(col_min(prev1, 1'b0), col_min(cur, 1'b0));
        b_left = (col > COL_W'(1)) ? min8(b_pair, col_min(prev2, 1'b0)) : b_pair;
    end

    always_comb begin
        grp.mask = {row_b && has_right, row_b && has_left,
                    row_a && has_right, row_a && has_left};

        grp.slot[0].value = a_left;
        grp.slot[0].row   = COORD_W'(row_up);
        grp.slot[0].col   = COORD_W'(col_left);
        grp.slot[0].done  = (row_up == h_last) && (col_left == w_last);

        grp.slot[1].value = a_pair;
        grp.slot[1].row   = COORD_W'(row_up);
        grp.slot[1].col   = COORD_W'(col);
        grp.slot[1].done  = (row_up == h_last) && (col == w_last);

        grp.slot[2].value = b_left;
        grp.slot[2].row   = COORD_W'(row);
        grp.slot[2].col   = COORD_W'(col_left);
        grp.slot[2].done  = (row == h_last) && (col_left == w_last);

        grp.slot[3].value = b_pair;
        grp.slot[3].row   = COORD_W'(row);
        grp.slot[3].col   = COORD_W'(col);
        grp.slot[3].done  = (row == h_last) && (col == w_last);
    end

endmodule

[rtl/gse_outbuf.sv]
// Output register for the results of one pixel; hands them out one request at a time.
// Depends on gse_pkg for the result group type and field widths.
module gse_outbuf (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  gse_pkg::grp_t                grp_in,
    output logic                         free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gse_pkg::TDATA_W-1:0]  m_tdata,  // eroded_value, out_row, out_col, zero pad
    output logic                         m_tlast,
    output logic                         m_tuser   // frame_done
);
    import gse_pkg::*;

    logic [NSLOT-1:0] mask_reg, mask_next, mask_rest;
    res_t [NSLOT-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] sel;
    res_t              res;
    logic              take;

    always_comb begin
        sel = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - NSLOT'(1));
    assign res       = slot_reg[sel];
    assign m_tvalid  = mask_reg != '0;
    assign take      = m_tvalid && m_tready;
    assign free      = !m_tvalid || (take && (mask_rest == '0));
    assign m_tdata   = {TPAD_W'(0), res.col, res.row, res.value};
    assign m_tlast   = mask_rest == '0;
    assign m_tuser   = res.done;

    always_comb begin
        mask_next = mask_reg;
        slot_next = slot_reg;
        if (load) begin
            mask_next = grp_in.mask;
            slot_next = grp_in.slot;
        end else if (take) begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
        slot_reg <= slot_next;
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("result group loaded over pending results");

    a_no_new_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> ((mask_reg & ~$past(mask_reg)) == '0))
        else $error("result mask gained a bit without a load");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end flagged on a result that is not the last of its pixel");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && m_tlast && !load) |=> !m_tvalid)
        else $error("results remain after the last one was taken");

endmodule

[rtl/grayscale_erode_3x3.sv]
// Top level of the streaming 3x3 grayscale erosion with a border-clipped window.
// Depends on gse_pkg, gse_ram (two line stores), gse_kernel and gse_outbuf.
//
// Usage: pixels of a frame enter on the s_ stream in raster order, one request per
// pixel, 8 bits in s_tdata. Results leave on the m_ stream, each carrying the
// minimum, its row and its column; m_tlast marks the last result caused by one
// input pixel and m_tuser marks the bottom-right pixel of the frame. Pixels of the
// first row and the first pixel of every row cause no result; a row-end pixel causes
// two, every other pixel of the last row causes two, and the bottom-right pixel four.
// The first result caused by a pixel is presented once the pixel has left the holding
// stage and its results are loaded into the output register. Throughput is one pixel
// per clock while each pixel causes at most one result and the receiver does not
// stall, bounded by the one-result-per-cycle output port otherwise. The line stores
// are read when a pixel is accepted and written later, when it leaves the holding stage.
// The cfg channel sets frame_width (index 0) and frame_height (index 1); values are
// clamped to 2..MAX. A write restarts the frame. Writes belong to idle periods.
// Reset restores 640x480 and the start of a frame; the line stores are not cleared
// and need no clearing pass. When the receiver stalls, results wait in the output
// register, one further pixel is held, and s_tready then falls.
module grayscale_erode_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gse_pkg::PIX_W-1:0]      s_tdata,   // pixel_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gse_pkg::TDATA_W-1:0]    m_tdata,   // eroded_value, out_row, out_col, pad
    output logic                           m_tlast,
    output logic                           m_tuser,   // frame_done
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gse_pkg::DIM_W-1:0]      cfg_data
);
    import gse_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int W_RST_LAST = (640 > MAX_WIDTH) ? MAX_WIDTH - 1 : 639;
    localparam int H_RST_LAST = (480 > MAX_HEIGHT) ? MAX_HEIGHT - 1 : 479;

    logic [COL_W-1:0] w_last_reg, w_last_next, w_clamp;
    logic [ROW_W-1:0] h_last_reg, h_last_next, h_clamp;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             s1_valid_reg, s1_valid_next;
    pix_t             s1_pix_reg, s1_pix_next;
    logic [COL_W-1:0] s1_col_reg, s1_col_next;
    logic [ROW_W-1:0] s1_row_reg, s1_row_next;
    col_t             win1_reg, win1_next, win2_reg, win2_next;
    logic [31:0]      cfg_wide;
    logic             cfg_we, acc, s1_adv, grp_free;
    pix_t             rd_older, rd_recent;
    col_t             cur;
    grp_t             grp;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_wide  = {{(32 - DIM_W){1'b0}}, cfg_data};
    assign acc       = s_tvalid && s_tready;
    assign s1_adv    = s1_valid_reg && grp_free;
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign cur       = '{top: rd_older, mid: rd_recent, bot: s1_pix_reg};

    always_comb begin
        if (cfg_wide < 32'(DIM_MIN)) begin
            w_clamp = COL_W'(DIM_MIN - 1);
        end else if (cfg_wide > 32'(MAX_WIDTH)) begin
            w_clamp = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_clamp = COL_W'(cfg_wide - 32'd1);
        end
        if (cfg_wide < 32'(DIM_MIN)) begin
            h_clamp = ROW_W'(DIM_MIN - 1);
        end else if (cfg_wide > 32'(MAX_HEIGHT)) begin
            h_clamp = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_clamp = ROW_W'(cfg_wide - 32'd1);
        end
    end

    always_comb begin
        w_last_next   = w_last_reg;
        h_last_next   = h_last_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        s1_valid_next = s1_valid_reg;
        s1_pix_next   = s1_pix_reg;
        s1_col_next   = s1_col_reg;
        s1_row_next   = s1_row_reg;
        win1_next     = win1_reg;
        win2_next     = win2_reg;

        if (s1_adv) begin
            s1_valid_next = 1'b0;
            win1_next     = cur;
            win2_next     = win1_reg;
        end
        if (acc) begin
            s1_valid_next = 1'b1;
            s1_pix_next   = s_tdata;
            s1_col_next   = col_reg;
            s1_row_next   = row_reg;
            if (col_reg == w_last_reg) begin
                col_next = '0;
                row_next = (row_reg == h_last_reg) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  w_last_next = w_clamp;
                CFG_FRAME_HEIGHT: h_last_next = h_clamp;
                default:          w_last_next = w_last_reg;
            endcase
            col_next  = '0;
            row_next  = '0;
            win1_next = '0;
            win2_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg   <= COL_W'(W_RST_LAST);
            h_last_reg   <= ROW_W'(H_RST_LAST);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win1_reg     <= '0;
            win2_reg     <= '0;
        end else begin
            w_last_reg   <= w_last_next;
            h_last_reg   <= h_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            win1_reg     <= win1_next;
            win2_reg     <= win2_next;
        end
        s1_pix_reg <= s1_pix_next;
        s1_col_reg <= s1_col_next;
        s1_row_reg <= s1_row_next;
    end

    gse_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (rd_recent),
        .re    (acc),
        .raddr (col_reg),
        .rdata (rd_older)
    );

    gse_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_recent_ram (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (acc),
        .raddr (col_reg),
        .rdata (rd_recent)
    );

    gse_kernel #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_kernel (
        .cur    (cur),
        .prev1  (win1_reg),
        .prev2  (win2_reg),
        .col    (s1_col_reg),
        .row    (s1_row_reg),
        .w_last (w_last_reg),
        .h_last (h_last_reg),
        .grp    (grp)
    );

    gse_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s1_adv),
        .grp_in   (grp),
        .free     (grp_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= w_last_reg) && (row_reg <= h_last_reg))
        else $error("pixel position outside the configured frame");

    a_held_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> ($stable(rd_older) && $stable(rd_recent)))
        else $error("line store read data changed under a held pixel");

    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && !cfg_we && (col_reg != w_last_reg)) |=>
            (col_reg == $past(col_reg) + COL_W'(1)))
        else $error("column position did not advance by one");

endmodule

[test/grayscale_erode_3x3_tb.sv]
// Self-checking testbench for grayscale_erode_3x3, the 3x3 erosion with a border-clipped window.
// Depends on gse_pkg and the RTL of the block; a built-in predictor supplies the expected results.
// Directed frames cover corners, clamping, restarts and the largest sizes; random frames follow.
module grayscale_erode_3x3_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gse_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 1024;

    typedef struct packed {
        pix_t               value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
        logic               done;
    } erode_res_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [DIM_W-1:0]     cfg_data  = '0;

    // Predictor state: line stores, the two previous window columns and the raster position.
    pix_t             older_line [MAX_W];
    pix_t             recent_line[MAX_W];
    col_t             prev_cols  [2];
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    logic [DIM_W-1:0] width_reg  = 11'd640;
    logic [DIM_W-1:0] height_reg = 11'd480;

    erode_res_t expected_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int pixels_sent    = 0;
    int results_seen   = 0;
    int frames_seen    = 0;
    int cfg_writes     = 0;

    grayscale_erode_3x3 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        int unsigned u;
        u = 32'(v);
        if (u < 32'(DIM_MIN)) begin
            return 32'(DIM_MIN);
        end
        if (u > hi) begin
            return hi;
        end
        return u;
    endfunction

    function automatic pix_t min_pix(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t vert_min(input col_t c, input bit use_top);
        pix_t v;
        v = min_pix(c.mid, c.bot);
        if (use_top) begin
            v = min_pix(v, c.top);
        end
        return v;
    endfunction

    function automatic void push_result(input pix_t v, input int unsigned row,
                                        input int unsigned col, input int unsigned w,
                                        input int unsigned h);
        erode_res_t r;
        r.value = v;
        r.row   = row[COORD_W-1:0];
        r.col   = col[COORD_W-1:0];
        r.last  = 1'b0;
        r.done  = (row == h - 1) && (col == w - 1);
        expected_q.push_back(r);
    endfunction

    // Results of one output row that the pixel in column c completes.
    function automatic void emit_output_row(input int unsigned row, input int unsigned c,
                                            input int unsigned w, input int unsigned h,
                                            input bit use_top, input col_t cur,
                                            input col_t p1, input col_t p2);
        pix_t v;
        if (c >= 1) begin
            v = min_pix(vert_min(p1, use_top), vert_min(cur, use_top));
            if (c >= 2) begin
                v = min_pix(v, vert_min(p2, use_top));
            end
            push_result(v, row, c - 1, w, h);
        end
        if (c == w - 1) begin
            v = min_pix(vert_min(p1, use_top), vert_min(cur, use_top));
            push_result(v, row, w - 1, w, h);
        end
    endfunction

    function automatic void predict_erosion(input pix_t pix);
        int unsigned w, h, c, r;
        int          n0;
        col_t        cur, p1, p2;
        erode_res_t  tail;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        if (col_pos >= w || row_pos >= h) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        cur.top = older_line[c];
        cur.mid = recent_line[c];
        cur.bot = pix;
        older_line[c]  = cur.mid;
        recent_line[c] = pix;
        p1 = prev_cols[0];
        p2 = prev_cols[1];
        n0 = expected_q.size();
        if (r >= 1) begin
            emit_output_row(r - 1, c, w, h, r >= 2, cur, p1, p2);
            if (r == h - 1) begin
                emit_output_row(r, c, w, h, 1'b0, cur, p1, p2);
            end
        end
        if (expected_q.size() > n0) begin
            tail = expected_q[expected_q.size() - 1];
            tail.last = 1'b1;
            expected_q[expected_q.size() - 1] = tail;
        end
        prev_cols[1] = p1;
        prev_cols[0] = cur;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic pix_t random_pixel();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 8'hFF : 8'h00;
            1: return pix_t'($urandom_range(255, 200));
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    // Checks each accepted result against the oldest prediction and drives the stalls.
    always @(posedge aclk) begin : result_check
        erode_res_t want, got;
        bit         ok;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata[PIX_W-1:0];
            got.row   = m_tdata[PIX_W +: COORD_W];
            got.col   = m_tdata[PIX_W+COORD_W +: COORD_W];
            got.last  = m_tlast;
            got.done  = m_tuser;
            results_seen++;
            if (m_tuser === 1'b1) begin
                frames_seen++;
            end
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result value %0d row %0d col %0d last %0b done %0b",
                             $realtime, got.value, got.row, got.col, got.last, got.done);
                end
            end else begin
                want = expected_q.pop_front();
                ok = (got.value === want.value) && (got.row === want.row) &&
                     (got.col === want.col) && (got.last === want.last) &&
                     (got.done === want.done);
                if (!ok) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected value %0d row %0d col %0d last %0b done %0b",
                                 $realtime, want.value, want.row, want.col, want.last,
                                 want.done);
                        $display("%0t: got      value %0d row %0d col %0d last %0b done %0b",
                                 $realtime, got.value, got.row, got.col, got.last, got.done);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_pixel(input pix_t pix);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        predict_erosion(pix);
    endtask

    // Waits until every predicted result has arrived, then lets the pipeline settle.
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        if (expected_q.size() != 0) begin
            mismatches += expected_q.size();
            $display("%0t: %0d expected results never arrived", $realtime, expected_q.size());
            expected_q.delete();
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[DIM_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == CFG_FRAME_WIDTH) begin
            width_reg = value[DIM_W-1:0];
        end else begin
            height_reg = value[DIM_W-1:0];
        end
        col_pos = 0;
        row_pos = 0;
        prev_cols[0] = '0;
        prev_cols[1] = '0;
        @(posedge aclk);
    endtask

    task automatic set_phase(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // The first pixels after reset lie in row zero of a 640-wide frame and give no result.
    task automatic test_reset_size();
        repeat (24) send_pixel(random_pixel());
    endtask

    // Corner windows on 2x2 frames set through clamped register values, two frames in a row.
    task automatic test_corners();
        pix_t corner_pix[8] = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h07, 8'hC8};
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 0);
        write_reg(CFG_FRAME_HEIGHT, 1);
        foreach (corner_pix[i]) begin
            send_pixel(corner_pix[i]);
        end
    endtask

    task automatic test_interior();
        pix_t grid[9] = '{8'd200, 8'd180, 8'd220, 8'd150, 8'd255, 8'd170, 8'd210, 8'd0,
                          8'd190};
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 3);
        write_reg(CFG_FRAME_HEIGHT, 3);
        foreach (grid[i]) begin
            send_pixel(grid[i]);
        end
    endtask

    // A register write in the middle of a frame starts a fresh frame.
    task automatic test_restart();
        repeat (5) send_pixel(random_pixel());
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 2);
        repeat (6) send_pixel(random_pixel());
    endtask

    // Oversized register values clamp to the largest frame: a partial wide row gives no
    // result, and a tall two-column frame keeps giving results of the upper rows only.
    task automatic test_largest_sizes();
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 2047);
        write_reg(CFG_FRAME_HEIGHT, 2);
        repeat (40) send_pixel(random_pixel());
        wait_drained();
        write_reg(CFG_FRAME_HEIGHT, 2047);
        write_reg(CFG_FRAME_WIDTH, 2);
        repeat (60) send_pixel(random_pixel());
    endtask

    // Random small frames: mostly complete ones, some followed by a second frame after
    // the wrap, and some cut short and restarted by the next register write.
    task automatic test_random_frames(input int send_pct, input int stall_pct,
                                      input int n_items);
        int unsigned w, h, total, kind;
        int          sent;
        sent = 0;
        wait_drained();
        set_phase(send_pct, stall_pct);
        while (sent < n_items) begin
            w = $urandom_range(12, 2);
            h = $urandom_range(8, 2);
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(40, 13);
            end
            kind = $urandom_range(9);
            wait_drained();
            if ($urandom_range(1)) begin
                write_reg(CFG_FRAME_WIDTH,
                          (w == 2 && $urandom_range(1)) ? $urandom_range(1) : w);
                write_reg(CFG_FRAME_HEIGHT, h);
            end else begin
                write_reg(CFG_FRAME_HEIGHT,
                          (h == 2 && $urandom_range(1)) ? $urandom_range(1) : h);
                write_reg(CFG_FRAME_WIDTH, w);
            end
            total = w * h;
            if (kind == 0) begin
                total = $urandom_range(w * h - 1, w + 1);
            end else if (kind == 1) begin
                total = 2 * w * h;
            end
            if (total > n_items - sent) begin
                total = n_items - sent;
            end
            repeat (total) send_pixel(random_pixel());
            sent += total;
        end
    endtask

    initial begin
        set_phase(0, 0);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_size();
        test_corners();
        test_interior();
        test_restart();
        test_largest_sizes();
        test_random_frames(0, 0, 75);
        test_random_frames(86, 0, 75);
        test_random_frames(0, 86, 75);
        test_random_frames(34, 34, 75);

        wait_drained();
        $display("Run covered %0d pixel requests, %0d results and %0d completed frames,",
                 pixels_sent, results_seen, frames_seen);
        $display("with %0d register writes and four flow-control settings; %0d mismatches.",
                 cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
